/* hw/rtl/sqrd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sqrd_pkg
// Shared types, constants and saturation helpers of the S^T D S factor core.
// ----------------------------------------------------------------------------
package sqrd_pkg;

	// Default build values.
	localparam int MAX_ORDER_DEF = 8;
	localparam int FRAC_BITS_DEF = 16;

	// Field widths.
	localparam int IDX_W  = 3;
	localparam int SIZE_W = 4;
	localparam int VAL_W  = 32;
	localparam int WIDE_W = 64;

	// Step counts of the shared shift-subtract unit.
	localparam logic [6:0] SQRT_STEPS = 7'd32;
	localparam logic [6:0] DIV_STEPS  = 7'd64;

	// Result status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOT_SYM = 2'd1;
	localparam logic [1:0] STAT_ZERO_PV = 2'd2;

	// Command to the shared arithmetic unit.
	typedef struct packed {
		logic start;
		logic is_sqrt;
	} unit_cmd_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CK_A,
		ST_CK_B,
		ST_CK_C,
		ST_EL_A,
		ST_EL_B,
		ST_CS_A,
		ST_CS_B,
		ST_CS_C,
		ST_CS_D,
		ST_DIFF,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} state_t;

	// Clamp a 65-bit exact result to the signed 64-bit range.
	function automatic logic signed [63:0] sat64(input logic signed [64:0] v);
		logic signed [63:0] r;
		begin
			if (v[64] != v[63]) begin
				r = v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			end else begin
				r = v[63:0];
			end
			return r;
		end
	endfunction

	// Saturating signed 64-bit add and subtract.
	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		begin
			s = {a[63], a} + {b[63], b};
			return sat64(s);
		end
	endfunction

	function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		begin
			s = {a[63], a} - {b[63], b};
			return sat64(s);
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sqrd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sqrd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sqrd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/sqrd_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sqrd_unit
// Shared shift-subtract unit: integer square root of a 64-bit value (one
// result bit a cycle) or unsigned 64 by 32 division (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module sqrd_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire sqrd_pkg::unit_cmd_t cmd,
	input  wire [63:0]         operand,
	input  wire [31:0]         divisor,
	output logic               done,
	output logic [63:0]        result
);

	logic        busy_q;
	logic        done_q;
	logic        is_sqrt_q;
	logic [6:0]  cnt_q;
	logic [32:0] rem_q;
	logic [63:0] work_q;
	logic [31:0] root_q;
	logic [31:0] divisor_q;

	logic [34:0] cand;
	logic [34:0] sub;
	logic [35:0] diff;
	logic        ge;
	logic [32:0] rem_next;

	// One trial subtraction serves both operations.
	always_comb begin
		if (is_sqrt_q) begin
			cand = {rem_q, work_q[63:62]};
			sub  = {1'b0, root_q, 2'b01};
		end else begin
			cand = {1'b0, rem_q[32:0], work_q[63]};
			sub  = {3'b000, divisor_q};
		end
		diff     = {1'b0, cand} - {1'b0, sub};
		ge       = ~diff[35];
		rem_next = ge ? diff[32:0] : cand[32:0];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.is_sqrt ? sqrd_pkg::SQRT_STEPS : sqrd_pkg::DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			is_sqrt_q <= cmd.is_sqrt;
			rem_q     <= 33'd0;
			work_q    <= operand;
			root_q    <= 32'd0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			if (is_sqrt_q) begin
				work_q <= {work_q[61:0], 2'b00};
				root_q <= {root_q[30:0], ge};
			end else begin
				work_q <= {work_q[62:0], ge};
			end
		end
	end

	assign done   = done_q;
	assign result = is_sqrt_q ? {32'd0, root_q} : work_q;

endmodule

`default_nettype wire

/* hw/rtl/symmetric_square_root_decomposition_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_square_root_decomposition_core
// Loads a symmetric matrix and factors it as A = S^T D S.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries one matrix element per request, addressed
// by row and column; tlast marks the final element and starts the run. The
// block takes one element per cycle while loading. After the final element
// it drops s_axis_tready, checks symmetry over each upper pair and then
// computes S row by row. For entry (i, j) it reads the element and forms
// the cross sum over earlier rows (one multiplier, one memory read port),
// then runs the shared root unit on the diagonal or the shared divide unit
// off it (skipped in a zero-pivot row), and then it hands over the result.
// Results leave on the master stream, upper triangle row by row; tlast marks
// the last one, tuser carries the status. A non-symmetric matrix gives one
// error result. When the receiver stalls, the sequencer waits with the
// result held in the output register. Reset clears control state and sets
// the matrix size to 4; the matrix and factor memories hold no defined data
// until written. The user must write the size register only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module symmetric_square_root_decomposition_core #(
	parameter int MAX_ORDER = sqrd_pkg::MAX_ORDER_DEF,
	parameter int FRAC_BITS = sqrd_pkg::FRAC_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// Size register write.
	input  wire         cfg_wr_en,
	input  wire [3:0]   cfg_wr_data,
	// Element requests: tdata = row[2:0], column[5:3], element[37:6], zeros.
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [39:0]  s_axis_tdata,
	input  wire         s_axis_tlast,
	// Result requests: tdata = out_row[2:0], out_column[5:3],
	// factor_value[37:6], diag_sign[39:38]; tuser = status.
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int RW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int DEPTH = (1 << RW) * 8;
	localparam int AW    = RW + 3;
	localparam logic [3:0] MAX_N = 4'(MAX_ORDER);

	sqrd_pkg::state_t state_q, state_d;

	logic [3:0]  size_q;
	logic [2:0]  nm1_q;
	logic [2:0]  i_q, j_q, k_q;
	logic [31:0] tmp_q;
	logic [31:0] elem_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] num_q;
	logic signed [63:0] prod_s1;
	logic signed [1:0]  sgn_s1;
	logic signed [1:0]  d_q;
	logic [31:0] piv_q;
	logic [1:0]  st_q;
	logic signed [1:0] sign_q [MAX_ORDER];

	logic        out_valid_q;
	logic [2:0]  out_row_q, out_col_q;
	logic [31:0] out_val_q;
	logic [1:0]  out_sign_q, out_stat_q;
	logic        out_last_q;

	// Input fields.
	logic [2:0]  in_row, in_col;
	logic [31:0] in_elem;
	assign in_row  = s_axis_tdata[2:0];
	assign in_col  = s_axis_tdata[5:3];
	assign in_elem = s_axis_tdata[37:6];

	logic in_acc, out_acc;
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Memories.
	logic          mat_we, fac_we;
	logic [AW-1:0] mat_waddr, mat_raddr, fac_waddr, fac_raddr;
	logic [31:0]   mat_rdata, fac_rdata, fac_wdata;

	sqrd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mat_ram (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(in_elem),
		.raddr(mat_raddr), .rdata(mat_rdata)
	);

	sqrd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_fac_ram (
		.clk(clk), .we(fac_we), .waddr(fac_waddr), .wdata(fac_wdata),
		.raddr(fac_raddr), .rdata(fac_rdata)
	);

	// Shared root and divide unit.
	sqrd_pkg::unit_cmd_t cmd;
	logic        unit_done;
	logic [63:0] unit_result;
	logic [63:0] num_mag;

	assign num_mag = num_q[63] ? (64'd0 - 64'(num_q)) : 64'(num_q);

	sqrd_unit u_unit (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .operand(num_mag),
		.divisor(piv_q), .done(unit_done), .result(unit_result)
	);

	// Load writes drop out-of-range positions.
	logic in_range;
	assign in_range  = (32'(in_row) < MAX_ORDER) && (32'(in_col) < MAX_ORDER);
	assign mat_we    = in_acc && in_range;
	assign mat_waddr = {in_row[RW-1:0], in_col};
	assign fac_waddr = {i_q[RW-1:0], j_q};

	// Read address selection.
	always_comb begin
		unique case (state_q)
			sqrd_pkg::ST_CK_B: mat_raddr = {j_q[RW-1:0], i_q};
			default:           mat_raddr = {i_q[RW-1:0], j_q};
		endcase
		unique case (state_q)
			sqrd_pkg::ST_CS_B: fac_raddr = {k_q[RW-1:0], j_q};
			default:           fac_raddr = {k_q[RW-1:0], i_q};
		endcase
	end

	// Clamped order at the final element.
	logic [3:0] n_eff;
	always_comb begin
		if (size_q == 4'd0) begin
			n_eff = 4'd1;
		end else if (size_q > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = size_q;
		end
	end

	// Cross-sum term with the row sign applied, and the difference term.
	logic signed [63:0] term;
	logic signed [63:0] elem_wide;
	always_comb begin
		if (sgn_s1 < 0) begin
			term = -prod_s1;
		end else if (sgn_s1 == 2'sd0) begin
			term = 64'sd0;
		end else begin
			term = prod_s1;
		end
		elem_wide = 64'(signed'(elem_q)) <<< FRAC_BITS;
	end

	// Saturated S entry from the unit result.
	logic        is_diag;
	logic        qneg;
	logic [31:0] ent_val;
	assign is_diag = (i_q == j_q);
	assign qneg    = num_q[63] != d_q[1];
	always_comb begin
		if (is_diag) begin
			ent_val = (unit_result[31:0] >= 32'h7FFF_FFFF) ? 32'h7FFF_FFFF
				: unit_result[31:0];
		end else if (qneg) begin
			ent_val = (unit_result >= 64'h8000_0000) ? 32'h8000_0000
				: (32'd0 - unit_result[31:0]);
		end else begin
			ent_val = (unit_result >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
				: unit_result[31:0];
		end
	end

	// Next state, unit commands and memory writes.
	logic zero_off;
	assign zero_off = !is_diag && (d_q == 2'sd0);
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		fac_we    = 1'b0;
		fac_wdata = ent_val;
		unique case (state_q)
			sqrd_pkg::ST_IDLE: begin
				if (in_acc && s_axis_tlast) begin
					state_d = (n_eff == 4'd1) ? sqrd_pkg::ST_EL_A : sqrd_pkg::ST_CK_A;
				end
			end
			sqrd_pkg::ST_CK_A: state_d = sqrd_pkg::ST_CK_B;
			sqrd_pkg::ST_CK_B: state_d = sqrd_pkg::ST_CK_C;
			sqrd_pkg::ST_CK_C: begin
				if (mat_rdata != tmp_q) begin
					state_d = sqrd_pkg::ST_EMIT;
				end else if (j_q == nm1_q && 3'(i_q + 3'd1) == nm1_q) begin
					state_d = sqrd_pkg::ST_EL_A;
				end else begin
					state_d = sqrd_pkg::ST_CK_A;
				end
			end
			sqrd_pkg::ST_EL_A: state_d = sqrd_pkg::ST_EL_B;
			sqrd_pkg::ST_EL_B: begin
				state_d = (i_q == 3'd0) ? sqrd_pkg::ST_DIFF : sqrd_pkg::ST_CS_A;
			end
			sqrd_pkg::ST_CS_A: state_d = sqrd_pkg::ST_CS_B;
			sqrd_pkg::ST_CS_B: state_d = sqrd_pkg::ST_CS_C;
			sqrd_pkg::ST_CS_C: state_d = sqrd_pkg::ST_CS_D;
			sqrd_pkg::ST_CS_D: begin
				state_d = (3'(k_q + 3'd1) == i_q) ? sqrd_pkg::ST_DIFF
					: sqrd_pkg::ST_CS_A;
			end
			sqrd_pkg::ST_DIFF: state_d = sqrd_pkg::ST_START;
			sqrd_pkg::ST_START: begin
				if (zero_off) begin
					fac_we    = 1'b1;
					fac_wdata = 32'd0;
					state_d   = sqrd_pkg::ST_EMIT;
				end else begin
					cmd.start   = 1'b1;
					cmd.is_sqrt = is_diag;
					state_d     = sqrd_pkg::ST_WAIT;
				end
			end
			sqrd_pkg::ST_WAIT: begin
				if (unit_done) begin
					fac_we  = 1'b1;
					state_d = sqrd_pkg::ST_EMIT;
				end
			end
			sqrd_pkg::ST_EMIT: begin
				if (out_acc) begin
					state_d = out_last_q ? sqrd_pkg::ST_IDLE : sqrd_pkg::ST_EL_A;
				end
			end
			default: state_d = sqrd_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sqrd_pkg::ST_IDLE;
			size_q      <= 4'd4;
			out_valid_q <= 1'b0;
			nm1_q       <= 3'd0;
			i_q         <= 3'd0;
			j_q         <= 3'd0;
			k_q         <= 3'd0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				sqrd_pkg::ST_IDLE: begin
					if (in_acc && s_axis_tlast) begin
						nm1_q <= 3'(n_eff - 4'd1);
						i_q   <= 3'd0;
						j_q   <= (n_eff == 4'd1) ? 3'd0 : 3'd1;
					end
				end
				sqrd_pkg::ST_CK_C: begin
					if (mat_rdata != tmp_q) begin
						out_valid_q <= 1'b1;
					end else if (j_q == nm1_q) begin
						if (3'(i_q + 3'd1) == nm1_q) begin
							i_q <= 3'd0;
							j_q <= 3'd0;
						end else begin
							i_q <= 3'(i_q + 3'd1);
							j_q <= 3'(i_q + 3'd2);
						end
					end else begin
						j_q <= 3'(j_q + 3'd1);
					end
				end
				sqrd_pkg::ST_EL_A: k_q <= 3'd0;
				sqrd_pkg::ST_CS_D: k_q <= 3'(k_q + 3'd1);
				sqrd_pkg::ST_START: begin
					if (zero_off) begin
						out_valid_q <= 1'b1;
					end
				end
				sqrd_pkg::ST_WAIT: begin
					if (unit_done) begin
						out_valid_q <= 1'b1;
					end
				end
				sqrd_pkg::ST_EMIT: begin
					if (out_acc && !out_last_q) begin
						if (j_q == nm1_q) begin
							i_q <= 3'(i_q + 3'd1);
							j_q <= 3'(i_q + 3'd1);
						end else begin
							j_q <= 3'(j_q + 3'd1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			sqrd_pkg::ST_CK_B: tmp_q <= mat_rdata;
			sqrd_pkg::ST_CK_C: begin
				out_row_q  <= 3'd0;
				out_col_q  <= 3'd0;
				out_val_q  <= 32'd0;
				out_sign_q <= 2'd0;
				out_stat_q <= sqrd_pkg::STAT_NOT_SYM;
				out_last_q <= 1'b1;
			end
			sqrd_pkg::ST_EL_A: acc_q <= 64'sd0;
			sqrd_pkg::ST_EL_B: elem_q <= mat_rdata;
			sqrd_pkg::ST_CS_B: tmp_q <= fac_rdata;
			sqrd_pkg::ST_CS_C: begin
				prod_s1 <= signed'(tmp_q) * signed'(fac_rdata);
				sgn_s1  <= sign_q[k_q[RW-1:0]];
			end
			sqrd_pkg::ST_CS_D: acc_q <= sqrd_pkg::sat_add64(acc_q, term);
			sqrd_pkg::ST_DIFF: num_q <= sqrd_pkg::sat_sub64(elem_wide, acc_q);
			sqrd_pkg::ST_START: begin
				if (is_diag) begin
					d_q  <= (num_q == 64'sd0) ? 2'sd0 : (num_q[63] ? -2'sd1 : 2'sd1);
					st_q <= (num_q == 64'sd0) ? sqrd_pkg::STAT_ZERO_PV : sqrd_pkg::STAT_OK;
				end
				if (zero_off) begin
					out_row_q  <= i_q;
					out_col_q  <= j_q;
					out_val_q  <= 32'd0;
					out_sign_q <= 2'd0;
					out_stat_q <= st_q;
					out_last_q <= 1'b0;
				end
			end
			sqrd_pkg::ST_WAIT: begin
				if (unit_done) begin
					out_row_q  <= i_q;
					out_col_q  <= j_q;
					out_val_q  <= ent_val;
					out_sign_q <= is_diag ? d_q : 2'd0;
					out_stat_q <= st_q;
					out_last_q <= is_diag && (i_q == nm1_q);
					if (is_diag) begin
						piv_q               <= ent_val;
						sign_q[i_q[RW-1:0]] <= d_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Port drive.
	assign s_axis_tready = (state_q == sqrd_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_sign_q, out_val_q, out_col_q, out_row_q};
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tlast  = out_last_q;

	// Loading and result delivery never overlap.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while a result is pending");

	// A pending result is always an upper-triangle entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_col_q >= out_row_q))
		else $error("result below the diagonal");

	// The symmetry error is the whole run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_stat_q == sqrd_pkg::STAT_NOT_SYM) |-> out_last_q)
		else $error("symmetry error not marked last");

	// The shared unit finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		unit_done |-> (state_q == sqrd_pkg::ST_WAIT))
		else $error("unit result outside the wait state");

endmodule

`default_nettype wire
